>>> hw/rtl/rca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

  // Pool and counter geometry
  localparam int ID_COUNT = 1024;
  localparam int ID_W     = $clog2(ID_COUNT);
  localparam int DEPTH_W  = $clog2(ID_COUNT + 1);
  localparam int COUNT_W  = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = '1;
  localparam depth_t DEPTH_FULL = DEPTH_W'(ID_COUNT);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_INC   = 2'd1,
    OP_DEC   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_ALLOC = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Free stack control and status
  typedef struct packed {
    logic rd_en;
    logic pop;
    logic push;
    logic clear;
    id_t  push_id;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    id_t  top_id;
  } stk_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rca_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per beat
interface rca_req_if;
  logic                       valid;
  logic                       ready;
  logic [rca_pkg::OP_W-1:0]   op;
  logic [rca_pkg::ID_W-1:0]   handle_id;

  modport source (output valid, output op, output handle_id, input ready);
  modport sink (input valid, input op, input handle_id, output ready);
endinterface

// Response channel: one result per beat
interface rca_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rca_pkg::ID_W-1:0]     result_id;
  logic [rca_pkg::STATUS_W-1:0] status;
  logic [rca_pkg::COUNT_W-1:0]  ref_count_after;
  logic                         freed;

  modport source (output valid, output result_id, output status, output ref_count_after,
                  output freed, input ready);
  modport sink (input valid, input result_id, input status, input ref_count_after,
                input freed, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/refcounted_id_allocator_unit.sv
// Flow: an accepted request beat is registered with its entry read and free stack read, then
// executed in S_EXEC once the response register is free; no new request is taken until then,
// as each operation is a read-then-write pass over the count memory and the free stack memory.
// Reset: synchronous; empties the free stack, zeroes the high-water counter, drops the
// response. No sweep: an ID counts as live only below the high-water counter.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_id_allocator_unit (
  input  wire logic clk,
  input  wire logic rst,
  rca_req_if.sink   req,
  rca_rsp_if.source rsp
);
  import rca_pkg::*;

  // Entry memory: {live, count} per ID
  typedef struct packed {
    logic   live;
    count_t count;
  } entry_t;

  entry_t    entry_mem [ID_COUNT];
  entry_t    entry_rd;
  logic      mem_we;
  id_t       mem_waddr;
  entry_t    mem_wdata;

  state_t    state, state_next;
  op_t       op_q;
  id_t       hid_q;
  depth_t    issued, issued_next;

  logic      accept, out_free, fire;
  stk_cmd_t  stk_cmd;
  stk_stat_t stk_stat;

  logic      out_valid;
  id_t       out_id;
  status_t   out_status;
  count_t    out_count;
  logic      out_freed;

  id_t       res_id;
  status_t   res_status;
  count_t    res_count;
  logic      res_freed;
  logic      is_live;

  rca_free_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stk_cmd),
    .stat (stk_stat)
  );

  // Handshake
  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign fire     = (state == S_EXEC) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs; no beat is taken while in reset
  always_comb begin
    case (state)
      S_IDLE:  req.ready = !rst;
      S_EXEC:  req.ready = 1'b0;
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= '0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_t'(req.op);
      hid_q <= req.handle_id;
    end
  end

  // Entry memory: read on accept, write back on execute
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_rd <= entry_mem[req.handle_id];
    end
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Live only if issued since the last clear and not yet released
  assign is_live = ({1'b0, hid_q} < issued) && entry_rd.live;

  // Execute step
  always_comb begin
    res_id      = hid_q;
    res_status  = ST_OK;
    res_count   = '0;
    res_freed   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = hid_q;
    mem_wdata   = '{live: 1'b0, count: '0};
    issued_next = issued;
    stk_cmd     = '{rd_en: accept, pop: 1'b0, push: 1'b0, clear: 1'b0, push_id: hid_q};

    case (op_q)
      OP_ALLOC: begin
        if (!stk_stat.empty) begin
          res_id      = stk_stat.top_id;
          mem_we      = fire;
          stk_cmd.pop = fire;
        end else if (issued != DEPTH_FULL) begin
          res_id      = issued[ID_W-1:0];
          mem_we      = fire;
          if (fire) issued_next = issued + depth_t'(1);
        end else begin
          res_id     = '0;
          res_status = ST_FULL;
        end
        mem_waddr = res_id;
        mem_wdata = '{live: 1'b1, count: '0};
      end
      OP_CLEAR: begin
        stk_cmd.clear = fire;
        if (fire) issued_next = '0;
      end
      OP_INC: begin
        if (!is_live) begin
          res_status = ST_NOT_ALLOC;
        end else if (entry_rd.count == COUNT_MAX) begin
          res_status = ST_SATURATED;
          res_count  = COUNT_MAX;
        end else begin
          res_count = entry_rd.count + count_t'(1);
          mem_we    = fire;
          mem_wdata = '{live: 1'b1, count: res_count};
        end
      end
      OP_DEC: begin
        if (!is_live) begin
          res_status = ST_NOT_ALLOC;
        end else if (entry_rd.count == '0) begin
          res_status = ST_UNDERFLOW;
        end else begin
          res_count = entry_rd.count - count_t'(1);
          mem_we    = fire;
          if (res_count == '0) begin
            // Last reference gone: release to the free stack
            mem_wdata    = '{live: 1'b0, count: '0};
            stk_cmd.push = fire;
            res_freed    = 1'b1;
          end else begin
            mem_wdata = '{live: 1'b1, count: res_count};
          end
        end
      end
      default: ;
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_id     <= res_id;
      out_status <= res_status;
      out_count  <= res_count;
      out_freed  <= res_freed;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_id       = out_id;
  assign rsp.status          = out_status;
  assign rsp.ref_count_after = out_count;
  assign rsp.freed           = out_freed;

endmodule

`default_nettype wire

>>> hw/rtl/rca_free_stack.sv
`timescale 1ns / 1ps
`default_nettype none

module rca_free_stack (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rca_pkg::stk_cmd_t  cmd,
  output rca_pkg::stk_stat_t      stat
);
  import rca_pkg::*;

  id_t    mem [ID_COUNT];
  depth_t depth;
  id_t    top_rd;
  depth_t depth_m1;

  assign depth_m1 = depth - depth_t'(1);

  // Depth pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.clear) begin
      depth <= '0;
    end else if (cmd.pop && depth != '0) begin
      depth <= depth_m1;
    end else if (cmd.push && depth != DEPTH_FULL) begin
      depth <= depth + depth_t'(1);
    end
  end

  // Push write; guarded so a push never goes past the pool size
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear && depth != DEPTH_FULL) begin
      mem[depth[ID_W-1:0]] <= cmd.push_id;
    end
  end

  // Registered read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      top_rd <= mem[depth_m1[ID_W-1:0]];
    end
  end

  assign stat.empty  = (depth == '0);
  assign stat.full   = (depth == DEPTH_FULL);
  assign stat.top_id = top_rd;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rca_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MIX_BEATS   = 300;
  localparam int TAIL_BEATS  = 260;
  localparam int LONG_HOLD   = 400;

  // One response beat as the block should return it
  typedef struct packed {
    id_t     id;
    status_t status;
    count_t  count;
    logic    freed;
  } result_beat_t;

  // Shadow of the pool: free stack, high-water mark, live flags, counts
  class handle_pool_tracker;
    id_t          free_ids[ID_COUNT];
    bit           live[ID_COUNT];
    count_t       refs[ID_COUNT];
    int unsigned  depth;
    int unsigned  issued;
    id_t          live_q[$];
    result_beat_t pending_results[$];
    int unsigned  mismatches;

    function new();
      depth      = 0;
      issued     = 0;
      mismatches = 0;
      foreach (live[i]) live[i] = 1'b0;
      foreach (refs[i]) refs[i] = '0;
      foreach (free_ids[i]) free_ids[i] = '0;
    endfunction

    function void drop_live(id_t hid);
      int hits[$];
      hits = live_q.find_first_index(x) with (x == hid);
      if (hits.size() > 0) live_q.delete(hits[0]);
    endfunction

    // Work out the response for an accepted request and update the shadow
    function void note_request(op_t op, id_t hid);
      result_beat_t r;
      id_t          id;
      r = '{id: hid, status: ST_OK, count: '0, freed: 1'b0};
      case (op)
        OP_ALLOC: begin
          if (depth > 0) begin
            depth--;
            id = free_ids[depth];
          end else if (issued < ID_COUNT) begin
            id = id_t'(issued);
            issued++;
          end else begin
            r.id     = '0;
            r.status = ST_FULL;
            pending_results = {pending_results, r};
            return;
          end
          live[id] = 1'b1;
          refs[id] = '0;
          live_q = {live_q, id};
          r.id = id;
        end
        OP_CLEAR: begin
          depth  = 0;
          issued = 0;
          foreach (live[i]) live[i] = 1'b0;
          live_q.delete();
        end
        OP_INC: begin
          if (!live[hid]) r.status = ST_NOT_ALLOC;
          else if (refs[hid] == COUNT_MAX) begin
            r.status = ST_SATURATED;
            r.count  = COUNT_MAX;
          end else begin
            refs[hid]++;
            r.count = refs[hid];
          end
        end
        default: begin
          if (!live[hid]) r.status = ST_NOT_ALLOC;
          else if (refs[hid] == '0) r.status = ST_UNDERFLOW;
          else begin
            refs[hid]--;
            r.count = refs[hid];
            if (refs[hid] == '0) begin
              // count hit zero: ID goes back on the free stack
              live[hid] = 1'b0;
              drop_live(hid);
              if (depth < ID_COUNT) begin
                free_ids[depth] = hid;
                depth++;
              end
              r.freed = 1'b1;
            end
          end
        end
      endcase
      pending_results = {pending_results, r};
    endfunction

    // Compare a response beat with the oldest expectation
    function void check_result(id_t id, logic [STATUS_W-1:0] status, count_t count,
                               logic freed);
      result_beat_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: unexpected response id=%0d status=%0d count=%0d freed=%0b",
                   id, status, count, freed);
        return;
      end
      e = pending_results.pop_front();
      if (id !== e.id || status !== e.status || count !== e.count || freed !== e.freed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: response exp id=%0d st=%0d cnt=%0d fr=%0b got id=%0d st=%0d cnt=%0d fr=%0b",
                   e.id, e.status, e.count, e.freed, id, status, count, freed);
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function id_t pick_live();
      if (live_q.size() == 0) return id_t'($urandom);
      return live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction
  endclass

  logic clk;
  logic rst;

  rca_req_if req_ch ();
  rca_rsp_if rsp_ch ();

  refcounted_id_allocator_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  handle_pool_tracker pool = new();

  int unsigned burst_left;
  bit          idle_on;
  bit          long_hold_req;
  int unsigned cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_ALLOC;
    req_ch.handle_id = '0;
    rsp_ch.ready     = 1'b0;
    burst_left       = 0;
    idle_on          = 1'b1;
    long_hold_req    = 1'b0;
  end

  // Response sink: ready pattern picked at random from four modes, plus long hold-offs on request
  initial begin : rsp_sink
    int unsigned hold_left;
    int unsigned mode;
    int unsigned tick;
    hold_left = 0;
    mode      = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (tick % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= $urandom_range(0, 1);
          2: rsp_ch.ready <= (tick % 4 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      pool.check_result(rsp_ch.result_id, rsp_ch.status, rsp_ch.ref_count_after,
                        rsp_ch.freed);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL refcounted_id_allocator_unit");
    $finish;
  end

  // Offer one request beat; called and returning at a falling edge
  task automatic send_beat(input op_t op, input id_t hid);
    int unsigned gap;
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.handle_id <= hid;
    do @(posedge clk); while (!req_ch.ready);
    pool.note_request(op, hid);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 20);
      gap        = idle_on ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Mostly inc/dec on live IDs, some allocs, some stray IDs and clears
  task automatic mixed_beat();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 24)      send_beat(OP_ALLOC, id_t'($urandom));
    else if (roll < 56) send_beat(OP_INC, pool.pick_live());
    else if (roll < 90) send_beat(OP_DEC, pool.pick_live());
    else if (roll < 94) send_beat(OP_INC, id_t'($urandom));
    else if (roll < 98) send_beat(OP_DEC, id_t'($urandom));
    else                send_beat(OP_CLEAR, id_t'($urandom));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unallocated access, underflow, free and LIFO reuse, clear
    send_beat(OP_INC, 10'd0);
    send_beat(OP_DEC, 10'd1023);
    send_beat(OP_ALLOC, 10'd1023);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_DEC, 10'd0);
    send_beat(OP_INC, 10'd0);
    send_beat(OP_INC, 10'd0);
    send_beat(OP_DEC, 10'd0);
    send_beat(OP_DEC, 10'd0);
    send_beat(OP_INC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_INC, 10'd1);
    send_beat(OP_DEC, 10'd1);
    send_beat(OP_INC, 10'd0);
    send_beat(OP_DEC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_INC, 10'd2);
    send_beat(OP_CLEAR, 10'd1023);
    send_beat(OP_INC, 10'd2);
    send_beat(OP_CLEAR, 10'd0);
    send_beat(OP_ALLOC, 10'd0);

    // Random mix, with one long receiver hold-off to back up the block
    long_hold_req = 1'b1;
    repeat (MIX_BEATS) mixed_beat();

    // Fill the pool from empty until it reports full, with some increments mixed in
    send_beat(OP_CLEAR, id_t'($urandom));
    while (pool.issued < ID_COUNT || pool.depth > 0) begin
      if ($urandom_range(0, 9) == 0) send_beat(OP_INC, pool.pick_live());
      else                           send_beat(OP_ALLOC, id_t'($urandom));
    end
    repeat (3) send_beat(OP_ALLOC, id_t'($urandom));

    // Drain and refill through a deep free stack
    repeat (TAIL_BEATS) mixed_beat();

    // One ID counted up and back down past zero, back to back
    idle_on = 1'b0;
    send_beat(OP_CLEAR, id_t'($urandom));
    send_beat(OP_ALLOC, 10'd0);
    long_hold_req = 1'b1;
    repeat (40) send_beat(OP_INC, 10'd0);
    repeat (42) send_beat(OP_DEC, 10'd0);
    send_beat(OP_INC, 10'd0);
    idle_on = 1'b1;
    repeat (20) mixed_beat();
    req_ch.valid <= 1'b0;

    // Wait out the last responses
    while (pool.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (pool.mismatches == 0 && pool.pending() == 0) begin
      $display("PASS refcounted_id_allocator_unit");
    end else begin
      $display("FAIL refcounted_id_allocator_unit");
    end
    $finish;
  end

endmodule
